// File: src/vcog_pkg.sv
// Package for the visit count obstacle grid: map geometry, command codes,
// controller states and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package vcog_pkg;

  // Map geometry. Two horizontally adjacent cells share one byte.
  localparam int MAP_SIZE    = 64;
  localparam int ROW_BYTES   = (MAP_SIZE + 1) / 2;
  localparam int STORE_BYTES = ROW_BYTES * MAP_SIZE;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // Field widths of one transaction.
  localparam int CMD_W      = 2;
  localparam int COORD_W    = 8;
  localparam int COUNT_W    = 3;
  localparam int NIBBLE_W   = 4;
  localparam int BYTE_W     = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Command codes. The unused code behaves as a query.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_VISIT    = 2'd0,
    CMD_SET_OBSTACLE = 2'd1,
    CMD_QUERY        = 2'd2,
    CMD_RESERVED     = 2'd3
  } vcog_cmd_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } vcog_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_we;  // write zero at the clear counter and advance it
    logic accept;    // capture the input transaction and start the read
    logic update;    // write the modified byte and load the output register
  } vcog_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;  // the clear counter sits on the last byte
    logic out_free;    // the output register can take a result this cycle
  } vcog_stat_t;

endpackage

`default_nettype wire

// File: src/visit_count_obstacle_grid_top.sv
// Top level of the visit count obstacle grid: stream ports, controller and datapath.
// Depends on vcog_pkg, vcog_ctrl, vcog_dp and vcog_ram.
`default_nettype none

// A square occupancy grid of MAP_SIZE by MAP_SIZE cells, each with a visit count
// that saturates at 7 and an obstacle flag; every input transaction adds a visit,
// sets the flag or queries one cell and yields exactly one result with the cell's
// state after the operation (all zero with coord_valid clear when the coordinates
// fall outside the map). After reset the block clears its store, one byte per
// cycle, over all STORE_BYTES bytes (2048 at the default size) and accepts no input
// until that pass ends. For each transaction the accept starts the store read,
// then the update state modifies the cell and writes it back, so s_axis_tready
// stays low from the accept until the write-back, set by the registered read of
// the single store. The result waits in an output register while the next
// transaction is accepted; the write-back waits while an earlier result has not
// been taken.
module visit_count_obstacle_grid_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [1:0] command, [9:2] x_coord, [17:10] y_coord, [23:18] zero
  input  wire logic [vcog_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [2:0] visit_count, [3] obstacle_flag, [4] coord_valid, [7:5] zero
  output logic      [vcog_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  import vcog_pkg::*;

  vcog_ctrl_t ctrl;
  vcog_stat_t stat;

  vcog_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .stat_i   (stat),
    .ctrl_o   (ctrl)
  );

  vcog_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: src/vcog_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module vcog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/vcog_ctrl.sv
// Controller of the visit count obstacle grid: clearing pass, accept and
// read-modify-write sequencing. Depends on vcog_pkg.
`default_nettype none

module vcog_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  output logic                     s_ready_o,
  input  wire vcog_pkg::vcog_stat_t stat_i,
  output vcog_pkg::vcog_ctrl_t     ctrl_o
);

  import vcog_pkg::*;

  vcog_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    s_ready_o       = 1'b0;
    ctrl_o          = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ctrl_o.clear_we = 1'b1;
        if (stat_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // Wait here while the previous result has not been taken.
        if (stat_i.out_free) begin
          ctrl_o.update = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/vcog_dp.sv
// Datapath of the visit count obstacle grid: address generation, cell store,
// nibble update and output register. Depends on vcog_pkg and vcog_ram.
`default_nettype none

module vcog_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire vcog_pkg::vcog_ctrl_t                ctrl_i,
  output vcog_pkg::vcog_stat_t                     stat_o,
  input  wire logic [vcog_pkg::IN_DATA_W-1:0]      in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [vcog_pkg::OUT_DATA_W-1:0]     out_data_o
);

  import vcog_pkg::*;

  logic [CMD_W-1:0]    in_cmd;
  logic [COORD_W-1:0]  in_x;
  logic [COORD_W-1:0]  in_y;
  logic                in_range;
  logic [ADDR_W-1:0]   rd_addr;

  logic [CMD_W-1:0]    cmd_q;
  logic                x_odd_q;
  logic                in_range_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [ADDR_W-1:0]   clr_cnt_q;
  logic                out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [BYTE_W-1:0]   rd_byte;
  logic [NIBBLE_W-1:0] cell_old;
  logic [NIBBLE_W-1:0] cell_new;
  logic [BYTE_W-1:0]   wr_byte;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;

  // Input fields and byte address of the addressed cell pair.
  assign in_cmd   = in_data_i[CMD_W-1:0];
  assign in_x     = in_data_i[CMD_W +: COORD_W];
  assign in_y     = in_data_i[CMD_W+COORD_W +: COORD_W];
  assign in_range = ({1'b0, in_x} < (COORD_W+1)'(MAP_SIZE)) &&
                    ({1'b0, in_y} < (COORD_W+1)'(MAP_SIZE));
  assign rd_addr  = ADDR_W'(in_y) * ADDR_W'(ROW_BYTES) + ADDR_W'(in_x >> 1);

  // Transaction capture at accept.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q      <= in_cmd;
      x_odd_q    <= in_x[0];
      in_range_q <= in_range;
      addr_q     <= rd_addr;
    end
  end

  // Clear counter for the pass over the store after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.clear_we) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
    end
  end

  assign stat_o.clear_done = (clr_cnt_q == ADDR_W'(STORE_BYTES - 1));

  // Cell update. An odd x lives in the low nibble, an even x in the high one.
  always_comb begin
    cell_old = x_odd_q ? rd_byte[NIBBLE_W-1:0] : rd_byte[BYTE_W-1:NIBBLE_W];
    cell_new = cell_old;
    case (cmd_q)
      CMD_ADD_VISIT: begin
        // The count saturates; it never carries into the flag bit.
        if (cell_old[COUNT_W-1:0] != COUNT_MAX) begin
          cell_new = cell_old + NIBBLE_W'(1);
        end
      end
      CMD_SET_OBSTACLE: begin
        cell_new[NIBBLE_W-1] = 1'b1;
      end
      default: begin
        cell_new = cell_old;
      end
    endcase
    wr_byte = x_odd_q ? {rd_byte[BYTE_W-1:NIBBLE_W], cell_new}
                      : {cell_new, rd_byte[NIBBLE_W-1:0]};
  end

  // Store write port: zeros during the clearing pass, else the updated byte.
  assign ram_we    = ctrl_i.clear_we || (ctrl_i.update && in_range_q);
  assign ram_waddr = ctrl_i.clear_we ? clr_cnt_q : addr_q;
  assign ram_wdata = ctrl_i.clear_we ? '0 : wr_byte;

  vcog_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ctrl_i.accept),
    .raddr_i(rd_addr),
    .rdata_o(rd_byte)
  );

  // Result: coord_valid, obstacle_flag, visit_count from the top bit down.
  always_comb begin
    out_data_d = '0;
    if (in_range_q) begin
      out_data_d = OUT_DATA_W'({1'b1, cell_new});
    end
  end

  // Output register; it takes a new result when empty or being drained.
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: src/vcog_checker.sv
// Port-level checker for the visit count obstacle grid and its bind to the top level.
// Depends on vcog_pkg and visit_count_obstacle_grid_top.
`default_nettype none

module vcog_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [vcog_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import vcog_pkg::*;

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result keeps its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A result for a cell outside the map carries no count and no flag.
  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[COUNT_W+1] |-> m_axis_tdata[COUNT_W:0] == '0)
    else $error("out-of-range result is not zero");

  // One transaction at a time: no accept in the cycle after an accept.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted in two consecutive cycles");

  // A result that appears on an idle output belongs to the last transaction
  // accepted; its update state could not stall, as the output was empty.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_acc, 2))
    else $error("result without a matching accept");

  // The padding bits of the result stay zero.
  a_out_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:COUNT_W+2] == '0)
    else $error("result padding not zero");

endmodule

bind visit_count_obstacle_grid_top vcog_checker u_vcog_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
